### design/mqsb_pkg.sv
// ----------------------------------------------------------------------------
// mqsb_pkg
// Shared types and codes for the multi-queue shared buffer.
// ----------------------------------------------------------------------------
package mqsb_pkg;

  // default sizes
  localparam int unsigned DEF_NUM_SLOTS  = 16;
  localparam int unsigned DEF_NUM_QUEUES = 8;
  localparam int unsigned DEF_DATA_BITS  = 32;

  // fixed field widths
  localparam int unsigned QID_W  = 3;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned STAT_W = 2;

  // operation codes
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOK,
    ST_ENQ_LINK,
    ST_DEQ_COMMIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic clr;
    logic accept;
    logic look;
    logic enq_link;
    logic deq_commit;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_deq;
    logic look_ok;
    logic out_free;
  } dp_sts_t;

endpackage

### design/mqsb_ctrl.sv
// ----------------------------------------------------------------------------
// mqsb_ctrl
// Sequencer for the shared buffer: clearing pass, then one request at a time.
// ----------------------------------------------------------------------------
module mqsb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mqsb_pkg::dp_sts_t sts_i,
  output mqsb_pkg::dp_cmd_t cmd_o
);
  import mqsb_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd_o.look = 1'b1;
        if (!sts_i.look_ok) begin
          state_d = ST_DONE;
        end else if (sts_i.is_deq) begin
          state_d = ST_DEQ_COMMIT;
        end else begin
          state_d = ST_ENQ_LINK;
        end
      end
      ST_ENQ_LINK: begin
        cmd_o.enq_link = 1'b1;
        state_d        = ST_DONE;
      end
      ST_DEQ_COMMIT: begin
        cmd_o.deq_commit = 1'b1;
        state_d          = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

endmodule

### design/mqsb_dp.sv
// ----------------------------------------------------------------------------
// mqsb_dp
// Pointer tables, slot store, free list head and result register.
// ----------------------------------------------------------------------------
module mqsb_dp #(
  parameter int unsigned NUM_SLOTS  = mqsb_pkg::DEF_NUM_SLOTS,
  parameter int unsigned NUM_QUEUES = mqsb_pkg::DEF_NUM_QUEUES,
  parameter int unsigned DATA_BITS  = mqsb_pkg::DEF_DATA_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mqsb_pkg::dp_cmd_t             cmd_i,
  output mqsb_pkg::dp_sts_t             sts_o,
  input  logic                          in_func_i,
  input  logic [mqsb_pkg::QID_W-1:0]    in_queue_id_i,
  input  logic [mqsb_pkg::WORD_W-1:0]   in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mqsb_pkg::WORD_W-1:0]   out_data_o,
  output logic [mqsb_pkg::STAT_W-1:0]   out_status_o
);
  import mqsb_pkg::*;

  localparam int unsigned IW      = $clog2(NUM_SLOTS);
  localparam int unsigned SW      = $clog2(NUM_SLOTS + 1);
  localparam int unsigned QAW     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned CLR_LEN = (NUM_SLOTS > NUM_QUEUES) ? NUM_SLOTS : NUM_QUEUES;
  localparam int unsigned CLR_W   = $clog2(CLR_LEN);
  localparam logic [SW-1:0] NULL_SLOT = SW'(NUM_SLOTS);

  // memories: link table, slot words, per-queue {head, tail}
  logic [SW-1:0]        link_mem [NUM_SLOTS];
  logic [DATA_BITS-1:0] data_mem [NUM_SLOTS];
  logic [2*SW-1:0]      qtab_mem [NUM_QUEUES];

  logic                 func_q;
  logic [QID_W-1:0]     qid_q;
  logic [DATA_BITS-1:0] word_q;
  logic [2*SW-1:0]      qent_q;
  logic [SW-1:0]        link_rd_q;
  logic [DATA_BITS-1:0] data_rd_q;
  logic [SW-1:0]        slot_q;
  logic [SW-1:0]        free_head_q, free_head_d;
  logic [CLR_W-1:0]     clr_cnt_q;
  logic [WORD_W-1:0]    res_data_q;
  logic [STAT_W-1:0]    res_status_q;
  logic                 out_valid_q;
  logic [WORD_W-1:0]    out_data_q;
  logic [STAT_W-1:0]    out_status_q;

  logic [8:0]           qid_in_wide, qid_wide;
  logic [63:0]          word_in_wide;
  logic signed [63:0]   data_ext;
  logic [SW-1:0]        cur_head, cur_tail;
  logic                 q_ok, head_ok, free_ok, enq_ok, deq_ok, is_deq, clr_last;
  logic                 enq_go;

  logic                 link_we, link_re;
  logic [IW-1:0]        link_waddr, link_raddr;
  logic [SW-1:0]        link_wdata;
  logic                 qt_we;
  logic [QAW-1:0]       qt_waddr;
  logic [2*SW-1:0]      qt_wdata;

  assign qid_in_wide  = 9'(in_queue_id_i);
  assign qid_wide     = 9'(qid_q);
  assign word_in_wide = 64'(in_data_i);
  assign data_ext     = 64'(signed'(data_rd_q));

  assign cur_head = qent_q[2*SW-1:SW];
  assign cur_tail = qent_q[SW-1:0];
  assign q_ok     = 32'(qid_q) < NUM_QUEUES;
  assign head_ok  = cur_head < NULL_SLOT;
  assign free_ok  = free_head_q < NULL_SLOT;
  assign enq_ok   = q_ok && free_ok;
  assign deq_ok   = q_ok && head_ok;
  assign is_deq   = (func_q == FUNC_DEQ);
  assign clr_last = (clr_cnt_q == CLR_W'(CLR_LEN - 1));
  assign enq_go   = cmd_i.look && !is_deq && enq_ok;

  assign sts_o.clr_last = clr_last;
  assign sts_o.is_deq   = is_deq;
  assign sts_o.look_ok  = is_deq ? deq_ok : enq_ok;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // single write port on the link table
  always_comb begin
    link_we    = 1'b0;
    link_waddr = '0;
    link_wdata = '0;
    if (cmd_i.clr && (32'(clr_cnt_q) < NUM_SLOTS)) begin
      link_we    = 1'b1;
      link_waddr = clr_cnt_q[IW-1:0];
      link_wdata = SW'(clr_cnt_q) + SW'(1);
    end else if (enq_go && head_ok) begin
      // append behind the current tail
      link_we    = 1'b1;
      link_waddr = cur_tail[IW-1:0];
      link_wdata = free_head_q;
    end else if (cmd_i.enq_link) begin
      link_we    = 1'b1;
      link_waddr = slot_q[IW-1:0];
      link_wdata = NULL_SLOT;
    end else if (cmd_i.deq_commit) begin
      // freed slot goes on top of the free list
      link_we    = 1'b1;
      link_waddr = slot_q[IW-1:0];
      link_wdata = free_head_q;
    end
  end

  assign link_re    = cmd_i.accept || (cmd_i.look && is_deq);
  assign link_raddr = cmd_i.accept ? free_head_q[IW-1:0] : cur_head[IW-1:0];

  always_comb begin
    qt_we    = 1'b0;
    qt_waddr = '0;
    qt_wdata = '0;
    if (cmd_i.clr && (32'(clr_cnt_q) < NUM_QUEUES)) begin
      qt_we    = 1'b1;
      qt_waddr = clr_cnt_q[QAW-1:0];
      qt_wdata = {NULL_SLOT, NULL_SLOT};
    end else if (enq_go) begin
      qt_we    = 1'b1;
      qt_waddr = qid_wide[QAW-1:0];
      qt_wdata = head_ok ? {cur_head, free_head_q} : {free_head_q, free_head_q};
    end else if (cmd_i.deq_commit) begin
      qt_we    = 1'b1;
      qt_waddr = qid_wide[QAW-1:0];
      qt_wdata = {link_rd_q, cur_tail};
    end
  end

  always_comb begin
    free_head_d = free_head_q;
    if (enq_go) begin
      free_head_d = link_rd_q;
    end else if (cmd_i.deq_commit) begin
      free_head_d = slot_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_re) begin
      link_rd_q <= link_mem[link_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq_go) begin
      data_mem[free_head_q[IW-1:0]] <= word_q;
    end
    if (cmd_i.look && is_deq) begin
      data_rd_q <= data_mem[cur_head[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (qt_we) begin
      qtab_mem[qt_waddr] <= qt_wdata;
    end
    if (cmd_i.accept) begin
      qent_q <= qtab_mem[qid_in_wide[QAW-1:0]];
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q <= in_func_i;
      qid_q  <= in_queue_id_i;
      word_q <= word_in_wide[DATA_BITS-1:0];
    end
    if (cmd_i.look) begin
      slot_q <= is_deq ? cur_head : free_head_q;
      if (!is_deq) begin
        res_data_q   <= '0;
        res_status_q <= enq_ok ? STATUS_OK : STATUS_FULL;
      end else if (!deq_ok) begin
        res_data_q   <= '1;
        res_status_q <= STATUS_EMPTY;
      end
    end
    if (cmd_i.deq_commit) begin
      res_data_q   <= data_ext[WORD_W-1:0];
      res_status_q <= STATUS_OK;
    end
    if (cmd_i.out_load) begin
      out_data_q   <= res_data_q;
      out_status_q <= res_status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= '0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      free_head_q <= free_head_d;
      if (cmd_i.clr && !clr_last) begin
        clr_cnt_q <= clr_cnt_q + CLR_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_data_q;
  assign out_status_o = out_status_q;

endmodule

### design/multi_queue_shared_buffer.sv
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer
// Several FIFO queues linked through one shared slot store with a free list.
// ----------------------------------------------------------------------------
//  channel   dir  ready/valid             tdata           tuser
//  s_axis    in   s_axis_tvalid/tready    data_in         func, queue_id
//  m_axis    out  m_axis_tvalid/tready    data_out        status
//
//  Requests are handled one at a time: a good enqueue or dequeue steps through
//  LOOK, then ENQ_LINK or DEQ_COMMIT, then DONE; a full or empty result goes
//  from LOOK straight to DONE. The steps are set by the registered table reads,
//  the single write port of the link table and the load of the result register.
//  After reset a clearing pass builds the free list and empties the queues;
//  s_axis_tready stays low during it.
//  A result waiting in the output register does not stall the next request
//  until that request itself is finished.
module multi_queue_shared_buffer #(
  parameter int unsigned NUM_SLOTS  = mqsb_pkg::DEF_NUM_SLOTS,
  parameter int unsigned NUM_QUEUES = mqsb_pkg::DEF_NUM_QUEUES,
  parameter int unsigned DATA_BITS  = mqsb_pkg::DEF_DATA_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] data_in
  input  logic [3:0]  s_axis_tuser,   // [0] func, [3:1] queue_id
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] data_out
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  import mqsb_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  mqsb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mqsb_dp #(
    .NUM_SLOTS  (NUM_SLOTS),
    .NUM_QUEUES (NUM_QUEUES),
    .DATA_BITS  (DATA_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_func_i     (s_axis_tuser[0]),
    .in_queue_id_i (s_axis_tuser[3:1]),
    .in_data_i     (s_axis_tdata),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_data_o    (m_axis_tdata),
    .out_status_o  (m_axis_tuser)
  );

  // one request in flight: no beat right after an accepted one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while another is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == STATUS_EMPTY) |-> (m_axis_tdata == '1))
    else $error("empty result without all-ones data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == STATUS_FULL) |-> (m_axis_tdata == '0))
    else $error("full result with nonzero data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == STATUS_OK) || (m_axis_tuser == STATUS_FULL) ||
                      (m_axis_tuser == STATUS_EMPTY))
    else $error("undefined status code");

  // a new result is only loaded once the previous beat has gone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !m_axis_tvalid || m_axis_tready)
    else $error("result register overwritten");

endmodule

### tb/sv/multi_queue_shared_buffer_tb.sv
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer_tb
// Self-checking bench for the multi-queue shared buffer. Enqueue and dequeue
// requests go in over the slave stream. A local linked-list model of the
// queues, slot links and free list predicts each result. Results on the
// master stream are checked in order against those predictions. Both sides
// idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_queue_shared_buffer_tb;
  import mqsb_pkg::*;

  localparam int unsigned NUM_SLOTS      = DEF_NUM_SLOTS;
  localparam int unsigned NUM_QUEUES     = DEF_NUM_QUEUES;
  localparam int unsigned SLOT_W         = $clog2(NUM_SLOTS + 1);
  localparam logic [SLOT_W-1:0] NULL_SLOT = SLOT_W'(NUM_SLOTS);
  localparam int unsigned RANDOM_ITEMS   = 530;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES   = 20;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [STAT_W-1:0] status;
  } buffer_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata = '0;   // [31:0] data_in
  logic [3:0]        s_axis_tuser = '0;   // [0] func, [3:1] queue_id
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [31:0]       m_axis_tdata;        // [31:0] data_out
  logic [1:0]        m_axis_tuser;        // [1:0] status

  // model of the buffer
  logic [SLOT_W-1:0] q_head_m [NUM_QUEUES];
  logic [SLOT_W-1:0] q_tail_m [NUM_QUEUES];
  logic [SLOT_W-1:0] link_m   [NUM_SLOTS];
  logic [WORD_W-1:0] word_m   [NUM_SLOTS];
  logic [SLOT_W-1:0] free_head_m;

  buffer_result_t    pending_results [$];
  buffer_result_t    oldest_result;
  int unsigned       error_count = 0;
  int unsigned       idle_cycles = 0;
  bit                gaps_on = 1'b1;

  multi_queue_shared_buffer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void clear_buffer_model();
    for (int i = 0; i < NUM_QUEUES; i++) begin
      q_head_m[i] = NULL_SLOT;
      q_tail_m[i] = NULL_SLOT;
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      link_m[i] = SLOT_W'(i + 1);
      word_m[i] = '0;
    end
    link_m[NUM_SLOTS-1] = NULL_SLOT;
    free_head_m = '0;
  endfunction

  function automatic buffer_result_t predict_buffer_op(input logic func,
                                                      input logic [QID_W-1:0] qid,
                                                      input logic [WORD_W-1:0] word);
    buffer_result_t    res;
    logic [SLOT_W-1:0] slot;
    res.word   = '0;
    res.status = STATUS_OK;
    if (func == FUNC_ENQ) begin
      slot = free_head_m;
      if (qid >= NUM_QUEUES || slot >= NUM_SLOTS) begin
        res.status = STATUS_FULL;
      end else begin
        free_head_m = link_m[slot];
        // a drained queue keeps a stale tail, so the head decides
        if (q_head_m[qid] >= NUM_SLOTS) begin
          q_head_m[qid] = slot;
        end else if (q_tail_m[qid] < NUM_SLOTS) begin
          link_m[q_tail_m[qid]] = slot;
        end
        link_m[slot]  = NULL_SLOT;
        q_tail_m[qid] = slot;
        word_m[slot]  = word;
      end
    end else begin
      slot = (qid < NUM_QUEUES) ? q_head_m[qid] : NULL_SLOT;
      if (slot >= NUM_SLOTS) begin
        res.status = STATUS_EMPTY;
        res.word   = '1;
      end else begin
        q_head_m[qid] = link_m[slot];
        link_m[slot]  = free_head_m;
        free_head_m   = slot;
        res.word      = word_m[slot];
      end
    end
    return res;
  endfunction

  // one request beat; prediction is taken at the accepting edge
  task automatic send_request(input logic func, input logic [QID_W-1:0] qid,
                              input logic [WORD_W-1:0] word);
    while (gaps_on && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= {qid, func};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(predict_buffer_op(func, qid, word));
  endtask

  task automatic wait_for_results();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_dequeue_empty();
    send_request(FUNC_DEQ, 3'd0, 32'h1234_5678);
    send_request(FUNC_DEQ, 3'd7, 32'hFFFF_FFFF);
  endtask

  task automatic test_fill_store();
    logic [WORD_W-1:0] word;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      case (i)
        0:       word = 32'h8000_0000;
        1:       word = 32'h7FFF_FFFF;
        2:       word = 32'h0000_0000;
        3:       word = 32'hFFFF_FFFF;
        default: word = $urandom;
      endcase
      send_request(FUNC_ENQ, QID_W'(i % NUM_QUEUES), word);
    end
    // free list is exhausted now
    send_request(FUNC_ENQ, 3'd5, 32'hDEAD_BEEF);
  endtask

  task automatic test_drain_fifo_order();
    send_request(FUNC_DEQ, 3'd0, '0);
    send_request(FUNC_DEQ, 3'd0, '0);
    send_request(FUNC_DEQ, 3'd0, '0);
    // queue 0 restarts with a stale tail
    send_request(FUNC_ENQ, 3'd0, 32'hA5A5_5A5A);
    send_request(FUNC_DEQ, 3'd0, '0);
  endtask

  task automatic test_random_traffic();
    int unsigned       sent;
    int unsigned       burst_len;
    int unsigned       enq_pct;
    int unsigned       qid_base;
    int unsigned       qid_span;
    logic              func;
    logic [QID_W-1:0]  qid;
    logic [WORD_W-1:0] word;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst_len = $urandom_range(40, 8);
      case ($urandom_range(2))
        0:       enq_pct = 85;
        1:       enq_pct = 15;
        default: enq_pct = 50;
      endcase
      // some bursts hammer one or two queues to build long chains
      qid_base = $urandom_range(NUM_QUEUES - 1);
      qid_span = ($urandom_range(1)) ? NUM_QUEUES : $urandom_range(2, 1);
      for (int b = 0; b < burst_len && sent < RANDOM_ITEMS; b++) begin
        if (sent == 150) gaps_on = 1'b0;
        if (sent == 280) gaps_on = 1'b1;
        if (sent == 320) begin
          s_axis_tvalid <= 1'b0;
          wait_for_results();
        end
        func = ($urandom_range(99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
        qid  = QID_W'((qid_base + $urandom_range(qid_span - 1)) % NUM_QUEUES);
        case ($urandom_range(15))
          0:       word = 32'h8000_0000;
          1:       word = 32'h7FFF_FFFF;
          2:       word = 32'h0000_0000;
          3:       word = 32'hFFFF_FFFF;
          default: word = $urandom;
        endcase
        send_request(func, qid, word);
        sent++;
      end
    end
  endtask

  // result checker and random back-pressure
  always @(posedge clk_i) begin
    if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat: data %h status %0d",
                 $time, m_axis_tdata, m_axis_tuser);
        error_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (m_axis_tdata !== oldest_result.word) begin
          $display("%0t: data_out mismatch: expected %h actual %h",
                   $time, oldest_result.word, m_axis_tdata);
          error_count++;
        end
        if (m_axis_tuser !== oldest_result.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, oldest_result.status, m_axis_tuser);
          error_count++;
        end
      end
    end
    m_axis_tready <= !(gaps_on && $urandom_range(99) < 17);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
        (m_axis_tvalid === 1'b1 && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("multi_queue_shared_buffer regression: fail");
      $finish;
    end
  end

  initial begin
    clear_buffer_model();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_dequeue_empty();
    test_fill_store();
    test_drain_fifo_order();
    test_random_traffic();
    s_axis_tvalid <= 1'b0;
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("multi_queue_shared_buffer regression: pass");
    end else begin
      $display("multi_queue_shared_buffer regression: fail");
    end
    $finish;
  end

endmodule
